// ----- hw/rtl/efla_pkg.sv -----
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types and constants for the extent free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efla_pkg;

    // width of every address or size field on the ports
    localparam int FIELD_W = 32;

    // end-of-space value loaded at reset
    localparam logic [FIELD_W-1:0] RESET_END = 32'd65632;

    // request kinds
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BEYOND   = 2'd1;
    localparam logic [1:0] ST_NO_SLOT  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] start_addr;
        logic [FIELD_W-1:0] length;
    } efla_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] granted_addr;
        logic [FIELD_W-1:0] granted_size;
        logic [1:0]         status;
    } efla_out_t;

    // per-entry flags from the compare unit
    typedef struct packed {
        logic usable;
        logic fit;
        logic touch_lo;
        logic touch_hi;
        logic empty;
    } efla_chk_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_REL_RD,
        S_REL_CHK,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_DONE
    } efla_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/efla_table.sv -----
// ----------------------------------------------------------------------------
// efla_table
// Extent table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efla_table #(
    parameter int DEPTH = 2048,
    parameter int IW    = 11,
    parameter int DW    = 64
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/efla_check.sv -----
// ----------------------------------------------------------------------------
// efla_check
// Shared compare and add unit applied to one table entry per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efla_check
    import efla_pkg::*;
#(
    parameter int AW = 32
) (
    input  wire logic [AW-1:0]  entry_off,
    input  wire logic [AW-1:0]  entry_size,
    input  wire logic [AW-1:0]  start,
    input  wire logic [AW+1:0]  len,
    output efla_chk_t           chk,
    output logic      [AW-1:0]  new_off,
    output logic      [AW-1:0]  new_size,
    output logic      [AW+1:0]  rend
);

    logic [AW+1:0] off_ext;
    logic [AW+1:0] size_ext;
    logic [AW+1:0] entry_end;

    assign off_ext   = {2'b00, entry_off};
    assign size_ext  = {2'b00, entry_size};
    assign entry_end = off_ext + size_ext;
    assign rend      = {2'b00, start} + len;

    // entry flags
    assign chk.usable   = (entry_off != '0);
    assign chk.fit      = chk.usable && (size_ext >= len);
    assign chk.touch_lo = chk.usable && (entry_end == {2'b00, start});
    assign chk.touch_hi = chk.usable && (rend == off_ext);
    assign chk.empty    = (entry_off == '0) && (entry_size == '0);

    // remainder of an extent after carving the front off
    assign new_size = entry_size - len[AW-1:0];
    assign new_off  = (new_size == '0) ? '0 : (entry_off + len[AW-1:0]);

endmodule

`default_nettype wire

// ----- hw/rtl/extent_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// extent_free_list_allocator
// First-fit extent allocator with coalescing over a linear address range.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each table visit is a memory read, then a
// compare in the shared check unit, and only slots below the fill mark are
// visited, the fill mark being the number of slots ever used (at most
// TABLE_ENTRIES). A release rescans the table from the start after each merge.
// The table needs no clearing pass: slots at or above the fill mark are empty
// by definition. Writing the configuration word loads the end-of-space pointer.
`timescale 1ns / 1ps
`default_nettype none

module extent_free_list_allocator
    import efla_pkg::*;
#(
    parameter int TABLE_ENTRIES = 2048,
    parameter int ADDR_WIDTH    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire efla_in_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output efla_out_t               out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [FIELD_W-1:0] cfg_data
);

    localparam int AW = ADDR_WIDTH;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = AW + 2;
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    efla_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hwm_reg, hwm_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] start_reg, start_next;
    logic [LW-1:0] len_reg, len_next;
    efla_out_t     res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    efla_out_t     out_data_reg, out_data_next;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [2*AW-1:0] rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [2*AW-1:0] wr_data;

    efla_chk_t     chk;
    logic [AW-1:0] new_off;
    logic [AW-1:0] new_size;
    logic [LW-1:0] rend;
    logic [AW-1:0] entry_off;
    logic [AW-1:0] entry_size;
    logic          scan_end;
    logic          out_free;
    logic [AW:0]   end_sum;

    assign entry_off  = rd_data[2*AW-1:AW];
    assign entry_size = rd_data[AW-1:0];
    assign scan_end   = (idx_reg >= hwm_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign end_sum    = {1'b0, end_reg} + {1'b0, len_reg[AW-1:0]};

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // extent table
    efla_table #(
        .DEPTH (TABLE_ENTRIES),
        .IW    (IW),
        .DW    (2 * AW)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // shared compare unit
    efla_check #(
        .AW (AW)
    ) u_check (
        .entry_off  (entry_off),
        .entry_size (entry_size),
        .start      (start_reg),
        .len        (len_reg),
        .chk        (chk),
        .new_off    (new_off),
        .new_size   (new_size),
        .rend       (rend)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.req_type == REQ_ALLOC) ? S_ALLOC_RD : S_REL_RD;
                end
            end
            S_ALLOC_RD:  state_next = scan_end ? S_DONE : S_ALLOC_CHK;
            S_ALLOC_CHK: state_next = chk.fit ? S_DONE : S_ALLOC_RD;
            S_REL_RD:
            begin
                if (!scan_end)
                begin
                    state_next = S_REL_CHK;
                end
                else if (rend >= {2'b00, end_reg})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SLOT_RD;
                end
            end
            S_REL_CHK:   state_next = S_REL_RD;
            S_SLOT_RD:   state_next = scan_end ? S_DONE : S_SLOT_CHK;
            S_SLOT_CHK:  state_next = chk.empty ? S_DONE : S_SLOT_RD;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb
    begin
        idx_next       = idx_reg;
        hwm_next       = hwm_reg;
        end_next       = end_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IW-1:0];
        wr_data        = '0;

        // output register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                start_next = in_data.start_addr[AW-1:0];
                len_next   = {2'b00, in_data.length[AW-1:0]};
                idx_next   = '0;
                res_next   = '0;
            end
            S_ALLOC_RD:
            begin
                if (!scan_end)
                begin
                    rd_en = 1'b1;
                end
                else if (end_sum[AW])
                begin
                    res_next.status = ST_OVERFLOW;
                end
                else
                begin
                    res_next.granted_addr = FIELD_W'(end_reg);
                    res_next.granted_size = FIELD_W'(len_reg[AW-1:0]);
                    res_next.status       = ST_OK;
                    end_next              = end_sum[AW-1:0];
                end
            end
            S_ALLOC_CHK:
            begin
                if (chk.fit)
                begin
                    wr_en                 = 1'b1;
                    wr_data               = {new_off, new_size};
                    res_next.granted_addr = FIELD_W'(entry_off);
                    res_next.granted_size = FIELD_W'(len_reg[AW-1:0]);
                    res_next.status       = ST_OK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REL_RD:
            begin
                if (!scan_end)
                begin
                    rd_en = 1'b1;
                end
                else if (rend > {2'b00, end_reg})
                begin
                    res_next.status = ST_BEYOND;
                end
                else if (rend == {2'b00, end_reg})
                begin
                    end_next        = start_reg;
                    res_next.status = ST_OK;
                end
                else
                begin
                    idx_next = '0;
                end
            end
            S_REL_CHK:
            begin
                // merge with a touching extent and rescan from the top
                if (chk.touch_lo || chk.touch_hi)
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + {2'b00, entry_size};
                    idx_next = '0;
                    if (chk.touch_lo)
                    begin
                        start_next = entry_off;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SLOT_RD:
            begin
                if (!scan_end)
                begin
                    rd_en = 1'b1;
                end
                else if (hwm_reg < FULL)
                begin
                    // take the first never-used slot
                    wr_en           = 1'b1;
                    wr_addr         = hwm_reg[IW-1:0];
                    wr_data         = {start_reg, len_reg[AW-1:0]};
                    hwm_next        = hwm_reg + 1'b1;
                    res_next.status = ST_OK;
                end
                else
                begin
                    res_next.status = ST_NO_SLOT;
                end
            end
            S_SLOT_CHK:
            begin
                if (chk.empty)
                begin
                    wr_en           = 1'b1;
                    wr_data         = {start_reg, len_reg[AW-1:0]};
                    res_next.status = ST_OK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        // configuration word loads the end pointer
        if (cfg_valid)
        begin
            end_next = cfg_data[AW-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            hwm_reg       <= '0;
            end_reg       <= RESET_END[AW-1:0];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hwm_reg       <= hwm_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        len_reg      <= len_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // fill mark never passes the table depth
    assert property (@(posedge clk) disable iff (!rst_n) hwm_reg <= FULL)
        else $error("fill mark beyond table depth");

    // fill mark never shrinks
    assert property (@(posedge clk) disable iff (!rst_n) hwm_reg >= $past(hwm_reg))
        else $error("fill mark decreased");

    // an accepted request closes the input until its word is produced
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // a failed request grants nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |-> (out_data.granted_size == '0))
        else $error("nonzero size on error");
`endif

endmodule

`default_nettype wire
